>>> rtl/snha_pkg.sv
// Shared types, constants and helper functions for the subnet next-host block.
// No dependencies; every other file in rtl/ uses this package by scoped names.
package snha_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned TotW  = 31;
  localparam int unsigned HbW   = 5;

  // One remainder cell per dividend bit.
  localparam int unsigned NumCells = AddrW;

  localparam logic [AddrW-1:0] MaskReset   = 32'hFFFF_FF00;
  localparam logic [HbW-1:0]   MaxHostBits = 5'd31;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [TotW-1:0]  total_t;

  // Payload handed from cell to cell along the remainder chain.
  typedef struct packed {
    addr_t  cur;
    addr_t  network;
    addr_t  bcast;
    addr_t  off;
    addr_t  shf;
    addr_t  rem;
    total_t total;
  } div_pl_t;

  // Payload between the two output stages.
  typedef struct packed {
    addr_t cand;
    addr_t last;
    addr_t network;
    logic  hit;
    logic  step_nz;
  } tail_pl_t;

  // Host total for a mask: the lowest set bit among bits 1 to 31 gives the
  // host bit count, which saturates at 31 when none of those bits is set.
  function automatic total_t host_total(addr_t mask);
    logic [HbW-1:0] hb;
    logic [AddrW-1:0] full;
    hb = MaxHostBits;
    for (int b = AddrW - 1; b >= 1; b--) begin
      if (mask[b]) begin
        hb = HbW'(b);
      end
    end
    full = (addr_t'(1) << hb) - addr_t'(1);
    return full[TotW-1:0];
  endfunction

endpackage

>>> rtl/subnet_next_host_address_top.sv
// Registered stages from input acceptance to out_valid: one entry stage,
// 32 remainder cells, two output stages; one item per cycle while out_ready is high.
// Each cell holds its item until its neighbor takes it, so a stalled output
// lets upstream cells keep filling; ready ripples back through the chain.
// Synchronous active-high rst empties every stage and loads the netmask
// 0xFFFFFF00 (host total 255). Depends on snha_pkg, snha_cell, snha_tail.
module subnet_next_host_address_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  snha_pkg::addr_t       cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  snha_pkg::addr_t       current_address,
  input  snha_pkg::addr_t       step_offset,
  output logic                  out_valid,
  input  logic                  out_ready,
  output snha_pkg::addr_t       next_address
);

  snha_pkg::addr_t   subnet_mask;
  snha_pkg::total_t  total;
  snha_pkg::div_pl_t front_next;
  snha_pkg::addr_t   network;

  logic              chain_valid [snha_pkg::NumCells+1];
  logic              chain_ready [snha_pkg::NumCells+1];
  snha_pkg::div_pl_t chain_pl    [snha_pkg::NumCells+1];

  // Netmask register; the host total is worked out once, when the mask is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      subnet_mask <= snha_pkg::MaskReset;
      total       <= snha_pkg::host_total(snha_pkg::MaskReset);
    end else if (cfg_wen) begin
      subnet_mask <= cfg_wdata;
      total       <= snha_pkg::host_total(cfg_wdata);
    end
  end

  // Entry stage: network and broadcast addresses, and the dividend for the chain.
  always_comb begin
    network          = current_address & subnet_mask;
    front_next.cur     = current_address;
    front_next.network = network;
    front_next.bcast   = network + {1'b0, total};
    front_next.off     = step_offset;
    front_next.shf     = step_offset;
    front_next.rem     = '0;
    front_next.total   = total;
  end

  assign in_ready = !chain_valid[0] || chain_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (in_ready) begin
      chain_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      chain_pl[0] <= front_next;
    end
  end

  // Remainder chain: one dividend bit per cell, step_offset modulo the host total.
  for (genvar i = 0; i < snha_pkg::NumCells; i++) begin : g_cell
    snha_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_pl     (chain_pl[i]),
      .in_ready  (chain_ready[i]),
      .out_valid (chain_valid[i+1]),
      .out_pl    (chain_pl[i+1]),
      .out_ready (chain_ready[i+1])
    );
  end

  // Output stages and the result register.
  snha_tail u_tail (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (chain_valid[snha_pkg::NumCells]),
    .in_pl        (chain_pl[snha_pkg::NumCells]),
    .in_ready     (chain_ready[snha_pkg::NumCells]),
    .out_valid    (out_valid),
    .next_address (next_address),
    .out_ready    (out_ready)
  );

endmodule

>>> rtl/snha_cell.sv
// One cell of the remainder chain: a single restoring-division step.
// Depends on snha_pkg for the payload type.
module snha_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  snha_pkg::div_pl_t in_pl,
  output logic              in_ready,
  output logic              out_valid,
  output snha_pkg::div_pl_t out_pl,
  input  logic              out_ready
);

  snha_pkg::addr_t   shifted;
  snha_pkg::addr_t   divisor;
  snha_pkg::div_pl_t pl_next;

  // Bring down the next dividend bit and subtract the divisor when it fits.
  // The partial remainder stays below the divisor, so its top bit is zero.
  always_comb begin
    shifted      = {in_pl.rem[snha_pkg::AddrW-2:0], in_pl.shf[snha_pkg::AddrW-1]};
    divisor      = {1'b0, in_pl.total};
    pl_next      = in_pl;
    pl_next.shf  = {in_pl.shf[snha_pkg::AddrW-2:0], 1'b0};
    pl_next.rem  = (shifted >= divisor) ? (shifted - divisor) : shifted;
  end

  // The cell takes an item whenever it is empty or its neighbor takes its item.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_pl <= pl_next;
    end
  end

endmodule

>>> rtl/snha_tail.sv
// Two output stages: pool bounds and candidate, then wrap and the result register.
// Depends on snha_pkg for the payload types.
module snha_tail (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  snha_pkg::div_pl_t in_pl,
  output logic              in_ready,
  output logic              out_valid,
  output snha_pkg::addr_t   next_address,
  input  logic              out_ready
);

  logic               a_valid;
  logic               a_ready;
  snha_pkg::tail_pl_t a_pl;
  snha_pkg::tail_pl_t a_next;
  snha_pkg::addr_t    total32;
  snha_pkg::addr_t    step;
  snha_pkg::addr_t    res_next;

  // First stage: last address, end-of-pool hit, reduced step and candidate.
  always_comb begin
    total32        = {1'b0, in_pl.total};
    a_next.network = in_pl.network;
    a_next.last    = (in_pl.bcast != '0) ? (in_pl.bcast - snha_pkg::addr_t'(1)) : '0;
    a_next.hit     = (in_pl.cur == a_next.last) || (in_pl.cur == in_pl.bcast);
    step           = (in_pl.off > total32) ? in_pl.rem : in_pl.off;
    a_next.cand    = in_pl.cur + step + snha_pkg::addr_t'(1);
    a_next.step_nz = (step != '0);
  end

  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_pl <= a_next;
    end
  end

  // Second stage: restart at the first host, wrap past the last address, or keep.
  always_comb begin
    if (a_pl.hit) begin
      res_next = a_pl.network + snha_pkg::addr_t'(1);
    end else if (a_pl.step_nz && (a_pl.cand > a_pl.last)) begin
      res_next = a_pl.network + (a_pl.cand - a_pl.last);
    end else begin
      res_next = a_pl.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      next_address <= res_next;
    end
  end

endmodule

>>> rtl/snha_checker.sv
// Port-level checks for the subnet next-host block, bound to the top level.
// Depends on snha_pkg and subnet_next_host_address_top.
module snha_checker (
  input logic            clk,
  input logic            rst,
  input logic            cfg_wen,
  input snha_pkg::addr_t cfg_wdata,
  input logic            in_valid,
  input logic            in_ready,
  input snha_pkg::addr_t current_address,
  input snha_pkg::addr_t step_offset,
  input logic            out_valid,
  input logic            out_ready,
  input snha_pkg::addr_t next_address
);

  // A result that is not taken stays, with the same value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_address))
    else $error("result item changed or vanished while stalled");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("out_valid high right after reset");

  // A result leaves only through a handshake.
  a_out_leave: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result item dropped without being taken");

  // With the output empty nothing downstream can block the input.
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

endmodule

bind subnet_next_host_address_top snha_checker u_snha_checker (.*);
